// ===== rtl/lsmdc_pkg.sv =====
// Shared types and constants for the linear sieve block.
// No dependencies; lsmdc_div and the top level refer to this package by scoped names.
package lsmdc_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BEGIN,
        ST_ENT,
        ST_PRD,
        ST_PMUL,
        ST_CMP,
        ST_MOD,
        ST_DDIV,
        ST_DMUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       flag;
        logic [1:0] mu;
        logic [7:0] d;
        logic [4:0] e;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    localparam int         EntryW   = $bits(t_entry);
    localparam int         CfgW     = 17;
    localparam logic [CfgW-1:0] CfgReset = 17'd65536;
    localparam logic [1:0] MuOne    = 2'b01;
    localparam logic [1:0] MuNeg    = 2'b11;
    localparam logic [1:0] MuZero   = 2'b00;
    localparam logic [7:0] DSat     = 8'd255;
    localparam logic [7:0] DOne     = 8'd1;
    localparam logic [7:0] DPrime   = 8'd2;
    localparam logic [4:0] EOne     = 5'd1;

endpackage

// ===== rtl/lsmdc_ram.sv =====
// Simple dual-address RAM: one write port, one registered read port.
// Depends on nothing.
module lsmdc_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lsmdc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Uses lsmdc_pkg for its status struct.
module lsmdc_div #(
    parameter int W = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_dividend,
    input  logic [W-1:0]          i_divisor,
    output logic [W-1:0]          o_quo,
    output logic [W-1:0]          o_rem,
    output lsmdc_pkg::t_div_stat  o_stat
);
    localparam int CntW = $clog2(W + 1);

    logic [W-1:0]    r_rem, r_quo, r_dvs;
    logic [CntW-1:0] r_cnt;
    logic            r_done;
    logic [W:0]      w_shift, w_diff;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CntW'(W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CntW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
endmodule

// ===== rtl/linear_sieve_mobius_divisor_count.sv =====
// Linear sieve top level: sequencer, number table, prime list, divider, output register.
// Depends on lsmdc_pkg, lsmdc_ram and lsmdc_div.
//
//   channel   handshake               payload
//   input     i_valid / o_stall       i_restart
//   output    o_valid / i_stall       o_number, o_is_prime, o_mobius,
//                                     o_divisor_count, o_past_limit
//   config    i_cfg_we                i_cfg_data (upper limit)
//
// A number passes BEGIN, ENT, its prime walk and EMIT; one and past-limit numbers go BEGIN to EMIT.
// Per prime walked: PRD, PMUL, CMP; then MOD (a divide, W = max(bits of MAX_N, 8)) when i*p
// is within the limit, and DDIV, DMUL for the prime that divides; running off the list leaves from PRD.
// After reset, and on each restart request, a clearing pass sweeps all MAX_N+1
// entries of the number table before any request is taken.
// o_stall is low only in IDLE; a held result parks the next result in EMIT.
module linear_sieve_mobius_divisor_count #(
    parameter int MAX_N       = 65536,
    parameter int PRIME_SLOTS = 8192
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_restart,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [$clog2(MAX_N+1)-1:0]   o_number,
    output logic                         o_is_prime,
    output logic signed [1:0]            o_mobius,
    output logic [7:0]                   o_divisor_count,
    output logic                         o_past_limit,
    input  logic                         i_cfg_we,
    input  logic [lsmdc_pkg::CfgW-1:0]   i_cfg_data
);
    localparam int NW  = $clog2(MAX_N + 1);
    localparam int CW  = $clog2(MAX_N + 2);
    localparam int XW  = CW + NW;
    localparam int DW  = (NW > 8) ? NW : 8;
    localparam int PAW = $clog2(PRIME_SLOTS);
    localparam int PCW = $clog2(PRIME_SLOTS + 1);
    localparam int TD  = MAX_N + 1;

    lsmdc_pkg::t_state r_state, n_state;
    logic [lsmdc_pkg::CfgW-1:0] r_cfg;
    logic [CW-1:0]  r_cur, n_cur, w_lim;
    logic [PCW-1:0] r_pc, n_pc, r_k, n_k;
    logic [NW-1:0]  r_caddr, n_caddr, r_rnum, n_rnum, r_p, n_p;
    logic           r_pend, n_pend, r_prime, n_prime, r_past, n_past;
    logic [1:0]     r_mu, n_mu;
    logic [7:0]     r_d, n_d, r_q, n_q;
    logic [4:0]     r_e, n_e;
    logic [XW-1:0]  r_x, n_x;
    logic           r_ovalid, n_ovalid, r_oprime, n_oprime, r_opast, n_opast;
    logic [NW-1:0]  r_onum, n_onum;
    logic [1:0]     r_omu, n_omu;
    logic [7:0]     r_od, n_od;

    logic             w_twe, w_pwe, w_dstart;
    logic [NW-1:0]    w_taddr;
    lsmdc_pkg::t_entry w_twdata, w_trdata;
    logic [NW-1:0]    w_prdata;
    logic [DW-1:0]    w_ddvd, w_ddvs, w_quo, w_rem;
    lsmdc_pkg::t_div_stat w_dstat;
    logic [8:0]       w_d2;
    logic [13:0]      w_dm;
    logic [5:0]       w_e1, w_e2;

    assign w_lim = (32'(r_cfg) > 32'(MAX_N)) ? CW'(MAX_N) : CW'(r_cfg);
    assign w_d2  = {r_d, 1'b0};
    assign w_e1  = 6'(r_e) + 6'd1;
    assign w_e2  = 6'(r_e) + 6'd2;
    assign w_dm  = r_q * 14'(w_e2);

    lsmdc_ram #(.W(lsmdc_pkg::EntryW), .D(TD)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_twe),
        .i_waddr (w_taddr),
        .i_wdata (w_twdata),
        .i_raddr (r_cur[NW-1:0]),
        .o_rdata (w_trdata)
    );

    lsmdc_ram #(.W(NW), .D(PRIME_SLOTS)) u_primes (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (r_pc[PAW-1:0]),
        .i_wdata (r_cur[NW-1:0]),
        .i_raddr (r_k[PAW-1:0]),
        .o_rdata (w_prdata)
    );

    lsmdc_div #(.W(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_ddvd),
        .i_divisor  (w_ddvs),
        .o_quo      (w_quo),
        .o_rem      (w_rem),
        .o_stat     (w_dstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsmdc_pkg::ST_CLEAR;
            r_cfg    <= lsmdc_pkg::CfgReset;
            r_cur    <= CW'(1);
            r_pc     <= '0;
            r_caddr  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cfg    <= i_cfg_we ? i_cfg_data : r_cfg;
            r_cur    <= n_cur;
            r_pc     <= n_pc;
            r_caddr  <= n_caddr;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_rnum   <= n_rnum;
        r_p      <= n_p;
        r_prime  <= n_prime;
        r_past   <= n_past;
        r_mu     <= n_mu;
        r_d      <= n_d;
        r_q      <= n_q;
        r_e      <= n_e;
        r_x      <= n_x;
        r_oprime <= n_oprime;
        r_opast  <= n_opast;
        r_onum   <= n_onum;
        r_omu    <= n_omu;
        r_od     <= n_od;
    end

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_pc     = r_pc;
        n_k      = r_k;
        n_caddr  = r_caddr;
        n_pend   = r_pend;
        n_rnum   = r_rnum;
        n_p      = r_p;
        n_prime  = r_prime;
        n_past   = r_past;
        n_mu     = r_mu;
        n_d      = r_d;
        n_q      = r_q;
        n_e      = r_e;
        n_x      = r_x;
        n_ovalid = r_ovalid & i_stall;
        n_oprime = r_oprime;
        n_opast  = r_opast;
        n_onum   = r_onum;
        n_omu    = r_omu;
        n_od     = r_od;
        w_twe    = 1'b0;
        w_taddr  = r_x[NW-1:0];
        w_twdata = '0;
        w_pwe    = 1'b0;
        w_dstart = 1'b0;
        w_ddvd   = DW'(r_cur[NW-1:0]);
        w_ddvs   = DW'(r_p);

        unique case (r_state)
            lsmdc_pkg::ST_CLEAR: begin
                w_twe   = 1'b1;
                w_taddr = r_caddr;
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == NW'(MAX_N)) begin
                    n_caddr = '0;
                    if (r_pend) begin
                        n_pend  = 1'b0;
                        n_cur   = CW'(1);
                        n_pc    = '0;
                        n_state = lsmdc_pkg::ST_BEGIN;
                    end else begin
                        n_state = lsmdc_pkg::ST_IDLE;
                    end
                end
            end
            lsmdc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_restart) begin
                        n_pend  = 1'b1;
                        n_caddr = '0;
                        n_state = lsmdc_pkg::ST_CLEAR;
                    end else begin
                        n_state = lsmdc_pkg::ST_BEGIN;
                    end
                end
            end
            lsmdc_pkg::ST_BEGIN: begin
                n_prime = 1'b0;
                n_past  = 1'b0;
                n_rnum  = r_cur[NW-1:0];
                if (r_cur > w_lim) begin
                    n_past  = 1'b1;
                    n_rnum  = '0;
                    n_mu    = lsmdc_pkg::MuZero;
                    n_d     = '0;
                    n_state = lsmdc_pkg::ST_EMIT;
                end else if (r_cur == CW'(1)) begin
                    n_mu    = lsmdc_pkg::MuOne;
                    n_d     = lsmdc_pkg::DOne;
                    n_cur   = r_cur + 1'b1;
                    n_state = lsmdc_pkg::ST_EMIT;
                end else begin
                    n_state = lsmdc_pkg::ST_ENT;
                end
            end
            lsmdc_pkg::ST_ENT: begin
                n_k     = '0;
                n_state = lsmdc_pkg::ST_PRD;
                if (!w_trdata.flag) begin
                    n_prime = 1'b1;
                    n_mu    = lsmdc_pkg::MuNeg;
                    n_d     = lsmdc_pkg::DPrime;
                    n_e     = lsmdc_pkg::EOne;
                    if (r_pc < PCW'(PRIME_SLOTS)) begin
                        w_pwe = 1'b1;
                        n_pc  = r_pc + 1'b1;
                    end
                end else begin
                    n_mu = w_trdata.mu;
                    n_d  = w_trdata.d;
                    n_e  = w_trdata.e;
                end
            end
            lsmdc_pkg::ST_PRD: begin
                if (r_k >= r_pc) begin
                    n_cur   = r_cur + 1'b1;
                    n_state = lsmdc_pkg::ST_EMIT;
                end else begin
                    n_state = lsmdc_pkg::ST_PMUL;
                end
            end
            lsmdc_pkg::ST_PMUL: begin
                n_p     = w_prdata;
                n_x     = XW'(r_cur) * XW'(w_prdata);
                n_state = lsmdc_pkg::ST_CMP;
            end
            lsmdc_pkg::ST_CMP: begin
                if (r_x > XW'(w_lim)) begin
                    n_cur   = r_cur + 1'b1;
                    n_state = lsmdc_pkg::ST_EMIT;
                end else begin
                    w_dstart = 1'b1;
                    n_state  = lsmdc_pkg::ST_MOD;
                end
            end
            lsmdc_pkg::ST_MOD: begin
                if (w_dstat.done) begin
                    if (w_rem == '0) begin
                        w_dstart = 1'b1;
                        w_ddvd   = DW'(r_d);
                        w_ddvs   = DW'(w_e1);
                        n_state  = lsmdc_pkg::ST_DDIV;
                    end else begin
                        w_twe          = 1'b1;
                        w_twdata.flag  = 1'b1;
                        w_twdata.mu    = 2'(-r_mu);
                        w_twdata.d     = w_d2[8] ? lsmdc_pkg::DSat : w_d2[7:0];
                        w_twdata.e     = lsmdc_pkg::EOne;
                        n_k            = r_k + 1'b1;
                        n_state        = lsmdc_pkg::ST_PRD;
                    end
                end
            end
            lsmdc_pkg::ST_DDIV: begin
                if (w_dstat.done) begin
                    n_q     = w_quo[7:0];
                    n_state = lsmdc_pkg::ST_DMUL;
                end
            end
            lsmdc_pkg::ST_DMUL: begin
                w_twe         = 1'b1;
                w_twdata.flag = 1'b1;
                w_twdata.mu   = lsmdc_pkg::MuZero;
                w_twdata.d    = (w_dm > 14'(lsmdc_pkg::DSat)) ? lsmdc_pkg::DSat : w_dm[7:0];
                w_twdata.e    = w_e1[4:0];
                n_cur         = r_cur + 1'b1;
                n_state       = lsmdc_pkg::ST_EMIT;
            end
            lsmdc_pkg::ST_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_onum   = r_rnum;
                    n_oprime = r_prime;
                    n_omu    = r_mu;
                    n_od     = r_d;
                    n_opast  = r_past;
                    n_state  = lsmdc_pkg::ST_IDLE;
                end
            end
            default: n_state = lsmdc_pkg::ST_IDLE;
        endcase
    end

    assign o_stall         = (r_state != lsmdc_pkg::ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_number        = r_onum;
    assign o_is_prime      = r_oprime;
    assign o_mobius        = r_omu;
    assign o_divisor_count = r_od;
    assign o_past_limit    = r_opast;

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dstat.busy |-> !w_dstart)
        else $error("divider restarted while busy");

    a_prime_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PCW'(PRIME_SLOTS))
        else $error("prime count beyond list depth");

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_twe && r_state != lsmdc_pkg::ST_CLEAR) |-> (r_x <= XW'(w_lim)))
        else $error("table write beyond limit");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsmdc_pkg::ST_EMIT && !r_ovalid) |=> o_valid)
        else $error("finished result not presented");
endmodule
